// ===== hdl/lfr_pkg.sv =====
// lfr_pkg: shared constants and types for the lru frame replacer
// no dependencies; used by the interfaces, the cells and the top level
package lfr_pkg;

    // payload widths fixed by the channel definitions
    localparam int FRAME_W = 6;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 7;

    // default capacity of the replacer
    localparam int DEF_NUM_FRAMES = 64;

    // command codes (code 3 is no operation)
    localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd2;

    // per-cell control from the top level
    typedef struct packed {
        logic shift;   // take the neighbor's entry (a lower entry was removed)
        logic load;    // take the new frame id (append at the tail)
    } t_cell_ctl;

endpackage

// ===== hdl/lfr_if.sv =====
// lfr_req_if / lfr_rsp_if: valid/ready channels of the lru frame replacer
// depends on lfr_pkg for payload widths
interface lfr_req_if import lfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [FRAME_W-1:0] frame_index;

    modport source (output valid, command, frame_index, input ready);
    modport sink   (input valid, command, frame_index, output ready);
endinterface

interface lfr_rsp_if import lfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [FRAME_W-1:0] victim_frame;
    logic [COUNT_W-1:0] evictable_count;

    modport source (output valid, found, victim_frame, evictable_count, input ready);
    modport sink   (input valid, found, victim_frame, evictable_count, output ready);
endinterface

// ===== hdl/lfr_cell.sv =====
// lfr_cell: one position of the recency order (frame id plus occupied flag)
// depends on lfr_pkg; instantiated in a row by lru_frame_replacer
module lfr_cell
    import lfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [FRAME_W-1:0] i_up_id,
    input  logic               i_up_vld,
    input  logic [FRAME_W-1:0] i_new_id,
    input  logic [FRAME_W-1:0] i_key,
    output logic [FRAME_W-1:0] o_id,
    output logic               o_vld,
    output logic               o_match
);

    logic [FRAME_W-1:0] r_id;
    logic               r_vld;
    logic [FRAME_W-1:0] n_id;
    logic               n_vld;

    // lookup compare against the requested frame
    assign o_match = r_vld && (r_id == i_key);

    // next entry: compact from the neighbor, append, or hold
    always_comb begin
        n_id  = r_id;
        n_vld = r_vld;
        priority if (i_ctl.shift) begin
            n_id  = i_up_id;
            n_vld = i_up_vld;
        end else if (i_ctl.load) begin
            n_id  = i_new_id;
            n_vld = 1'b1;
        end else begin
            n_id  = r_id;
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_id <= n_id;
    end

    assign o_id  = r_id;
    assign o_vld = r_vld;

endmodule

// ===== hdl/lfr_scan.sv =====
// lfr_scan: log-depth prefix or, marks every cell at or above a removal
// depends on lfr_pkg for the default width
module lfr_scan
    import lfr_pkg::*;
#(
    parameter int WIDTH = DEF_NUM_FRAMES
) (
    input  logic [WIDTH-1:0] i_bits,
    output logic [WIDTH-1:0] o_prefix
);

    localparam int LVLS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] w_lvl [0:LVLS];

    assign w_lvl[0] = i_bits;

    // kogge-stone style levels, span doubles each level
    for (genvar l = 0; l < LVLS; l++) begin : g_lvl
        for (genvar k = 0; k < WIDTH; k++) begin : g_bit
            if (k >= (1 << l)) begin : g_or
                assign w_lvl[l+1][k] = w_lvl[l][k] | w_lvl[l][k-(1<<l)];
            end else begin : g_pass
                assign w_lvl[l+1][k] = w_lvl[l][k];
            end
        end
    end

    assign o_prefix = w_lvl[LVLS];

endmodule

// ===== hdl/lru_frame_replacer.sv =====
// lru_frame_replacer: lru replacement policy over frame ids, built as a row of cells
// depends on lfr_pkg, lfr_if, lfr_cell and lfr_scan
//
//  channel  dir  handshake      payload
//  i_req    in   valid/ready    command, frame_index
//  o_rsp    out  valid/ready    found, victim_frame, evictable_count
//
// one transaction per cycle while the response register is free: a request is matched
// and compacted in the cycle it is taken, the response is held in one output register
// i_req.ready is high while the output register is empty or being drained
// cell 0 holds the oldest frame; the compare row and the prefix scan set the path
// synchronous active-low reset empties every cell and the count, no clearing pass
module lru_frame_replacer
    import lfr_pkg::*;
#(
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lfr_req_if.sink       i_req,
    lfr_rsp_if.source     o_rsp
);

    localparam int CNT_W = $clog2(NUM_FRAMES + 1);

    t_cell_ctl          w_ctl   [NUM_FRAMES];
    logic [FRAME_W-1:0] w_id    [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] w_vld;
    logic [NUM_FRAMES-1:0] w_match;
    logic [NUM_FRAMES-1:0] w_rem;
    logic [NUM_FRAMES-1:0] w_shift;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_rsp_vld;
    logic               r_found;
    logic [FRAME_W-1:0] r_victim;
    logic [COUNT_W-1:0] r_ecount;

    logic w_accept;
    logic w_id_ok;
    logic w_present;
    logic w_do_victim;
    logic w_do_pin;
    logic w_do_unpin;

    // handshake
    assign i_req.ready = !r_rsp_vld || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // decode the request
    assign w_id_ok     = (32'(i_req.frame_index) < NUM_FRAMES);
    assign w_present   = |w_match;
    assign w_do_victim = w_accept && (i_req.command == CMD_VICTIM) && w_vld[0];
    assign w_do_pin    = w_accept && (i_req.command == CMD_PIN) && w_id_ok && w_present;
    assign w_do_unpin  = w_accept && (i_req.command == CMD_UNPIN) && w_id_ok && !w_present
                         && (32'(r_count) < NUM_FRAMES);

    // removal point: matching cell for pin, oldest cell for victim
    always_comb begin
        w_rem    = w_match & {NUM_FRAMES{w_do_pin}};
        w_rem[0] = w_rem[0] | w_do_victim;
    end

    lfr_scan #(
        .WIDTH (NUM_FRAMES)
    ) u_scan (
        .i_bits   (w_rem),
        .o_prefix (w_shift)
    );

    // row of cells
    for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
        logic [FRAME_W-1:0] w_up_id;
        logic               w_up_vld;

        if (k == NUM_FRAMES - 1) begin : g_top
            assign w_up_id  = '0;
            assign w_up_vld = 1'b0;
        end else begin : g_mid
            assign w_up_id  = w_id[k+1];
            assign w_up_vld = w_vld[k+1];
        end

        assign w_ctl[k].shift = w_shift[k];
        assign w_ctl[k].load  = w_do_unpin && (r_count == CNT_W'(k));

        lfr_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[k]),
            .i_up_id  (w_up_id),
            .i_up_vld (w_up_vld),
            .i_new_id (i_req.frame_index),
            .i_key    (i_req.frame_index),
            .o_id     (w_id[k]),
            .o_vld    (w_vld[k]),
            .o_match  (w_match[k])
        );
    end

    // occupancy count
    assign n_count = r_count - CNT_W'(w_do_victim || w_do_pin) + CNT_W'(w_do_unpin);

    // count and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
        if (w_accept) begin
            r_found  <= w_do_victim;
            r_victim <= w_do_victim ? w_id[0] : '0;
            r_ecount <= COUNT_W'(n_count);
        end
    end

    assign o_rsp.valid           = r_rsp_vld;
    assign o_rsp.found           = r_found;
    assign o_rsp.victim_frame    = r_victim;
    assign o_rsp.evictable_count = r_ecount;

    // count tracks the occupied cells
    a_count_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) == 32'(r_count))
        else $error("occupancy count differs from occupied cells");

    // occupied cells stay packed toward the oldest end
    a_packed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld & (w_vld + 1'b1)) == '0)
        else $error("gap in recency order");

    // the requested frame id is held in at most one cell
    a_unique : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("frame id held twice");

    // an accepted transaction always leaves a response pending
    a_rsp_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_rsp_vld)
        else $error("response lost");

endmodule

// ===== sim/tb_lru_frame_replacer.sv =====
// tb_lru_frame_replacer: self-checking testbench for the lru frame replacer
// depends on lfr_pkg, lfr_if and lru_frame_replacer; directed table then biased random traffic
// every response is checked against a typed reply or a behavioral lru order kept in the testbench
`timescale 1ns / 100ps

module tb_lru_frame_replacer;
    import lfr_pkg::*;

    // unused command code, the block treats it as no operation
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int WORK_TARGET   = 1400;
    localparam int HOLD_CYCLES   = 80;
    localparam int DIRECTED_LEN  = 23;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [FRAME_W-1:0] frame_index;
    } t_request;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] victim_frame;
        logic [COUNT_W-1:0] evictable_count;
    } t_reply;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_reply   want;
    } t_step_row;

    // directed rows: typed replies where they are obvious, predictor otherwise
    localparam t_step_row DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{'{CMD_VICTIM, 6'd0},  1'b1, '{1'b0, 6'd0,  7'd0}},  // victim on empty set
        '{'{CMD_PIN,    6'd5},  1'b1, '{1'b0, 6'd0,  7'd0}},  // pin of absent frame
        '{'{CMD_NOP,    6'd63}, 1'b1, '{1'b0, 6'd0,  7'd0}},  // unused command
        '{'{CMD_UNPIN,  6'd0},  1'b1, '{1'b0, 6'd0,  7'd1}},
        '{'{CMD_UNPIN,  6'd63}, 1'b1, '{1'b0, 6'd0,  7'd2}},
        '{'{CMD_UNPIN,  6'd0},  1'b1, '{1'b0, 6'd0,  7'd2}},  // unpin of present frame
        '{'{CMD_UNPIN,  6'd42}, 1'b1, '{1'b0, 6'd0,  7'd3}},
        '{'{CMD_UNPIN,  6'd21}, 1'b1, '{1'b0, 6'd0,  7'd4}},
        '{'{CMD_PIN,    6'd63}, 1'b1, '{1'b0, 6'd0,  7'd3}},  // pin from the middle
        '{'{CMD_PIN,    6'd21}, 1'b1, '{1'b0, 6'd0,  7'd2}},  // pin of the newest
        '{'{CMD_PIN,    6'd63}, 1'b1, '{1'b0, 6'd0,  7'd2}},
        '{'{CMD_VICTIM, 6'd33}, 1'b1, '{1'b1, 6'd0,  7'd1}},
        '{'{CMD_VICTIM, 6'd0},  1'b1, '{1'b1, 6'd42, 7'd0}},
        '{'{CMD_VICTIM, 6'd63}, 1'b1, '{1'b0, 6'd0,  7'd0}},
        '{'{CMD_UNPIN,  6'd63}, 1'b0, '0},
        '{'{CMD_UNPIN,  6'd1},  1'b0, '0},
        '{'{CMD_UNPIN,  6'd62}, 1'b0, '0},
        '{'{CMD_PIN,    6'd63}, 1'b0, '0},                     // pin of the oldest
        '{'{CMD_UNPIN,  6'd63}, 1'b0, '0},
        '{'{CMD_NOP,    6'd0},  1'b0, '0},
        '{'{CMD_VICTIM, 6'd0},  1'b0, '0},
        '{'{CMD_VICTIM, 6'd0},  1'b0, '0},
        '{'{CMD_VICTIM, 6'd0},  1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    lfr_req_if req_ch ();
    lfr_rsp_if rsp_ch ();

    lru_frame_replacer #(
        .NUM_FRAMES (DEF_NUM_FRAMES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // behavioral lru order, oldest frame at position 0
    logic [FRAME_W-1:0] lru_order [DEF_NUM_FRAMES];
    bit                 in_set [DEF_NUM_FRAMES];
    int                 set_count;

    t_reply expected_q [$];
    int     mismatches;
    int     work_items;
    int     burst_left;
    int     cycle_count;
    bit     hold_req;

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // remove one position and close the gap toward the oldest end
    function automatic void drop_entry(int pos);
        for (int k = pos; k + 1 < set_count; k++)
            lru_order[k] = lru_order[k + 1];
        set_count--;
    endfunction

    // apply one transaction to the lru order and return the reply it should give
    function automatic t_reply apply_lru(t_request r);
        t_reply rep;
        int     pos;
        rep = '0;
        pos = -1;
        case (r.command)
            CMD_VICTIM: begin
                if (set_count != 0) begin
                    rep.found        = 1'b1;
                    rep.victim_frame = lru_order[0];
                    in_set[lru_order[0]] = 1'b0;
                    drop_entry(0);
                end
            end
            CMD_PIN: begin
                if (in_set[r.frame_index]) begin
                    for (int k = 0; k < set_count; k++)
                        if (pos < 0 && lru_order[k] == r.frame_index)
                            pos = k;
                    drop_entry(pos);
                    in_set[r.frame_index] = 1'b0;
                end
            end
            CMD_UNPIN: begin
                if (!in_set[r.frame_index] && set_count < DEF_NUM_FRAMES) begin
                    lru_order[set_count] = r.frame_index;
                    set_count++;
                    in_set[r.frame_index] = 1'b1;
                end
            end
            default: ;
        endcase
        rep.evictable_count = COUNT_W'(set_count);
        return rep;
    endfunction

    // a frame currently in the set, or any frame when the set is empty
    function automatic logic [FRAME_W-1:0] pick_present();
        if (set_count == 0)
            return FRAME_W'($urandom_range(DEF_NUM_FRAMES - 1));
        return lru_order[$urandom_range(set_count - 1)];
    endfunction

    // drive one request transaction, record its expected reply, then maybe idle
    task automatic offer(t_request r, bit typed = 1'b0, t_reply typed_reply = '0);
        t_reply predicted;
        req_ch.valid       <= 1'b1;
        req_ch.command     <= r.command;
        req_ch.frame_index <= r.frame_index;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predicted = apply_lru(r);
        expected_q.push_back(typed ? typed_reply : predicted);
        if (r.command != CMD_NOP)
            work_items++;
        burst_left--;
        if (burst_left <= 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 12);
        end
    endtask

    // stop offering and wait for every outstanding reply
    task automatic settle_requests();
        req_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // mixed traffic, weighted by how full the set is
    task automatic run_churn(int n);
        t_request r;
        int       pick;
        int       unpin_w;
        for (int i = 0; i < n; i++) begin
            pick    = $urandom_range(99);
            unpin_w = (set_count < 16) ? 60 : (set_count > 48) ? 25 : 40;
            r.frame_index = FRAME_W'($urandom_range(DEF_NUM_FRAMES - 1));
            if (pick < 4) begin
                r.command = CMD_NOP;
            end else if (pick < 4 + unpin_w) begin
                r.command = CMD_UNPIN;
            end else if (pick < 4 + unpin_w + (96 - unpin_w) / 2) begin
                r.command = CMD_PIN;
                if ($urandom_range(9) < 7)
                    r.frame_index = pick_present();
            end else begin
                r.command = CMD_VICTIM;
            end
            offer(r);
        end
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // response receiver: own stall pattern plus an occasional long hold-off
    initial begin
        int run_left;
        int hold_left;
        run_left  = 0;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                run_left  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else if (rsp_ch.ready === 1'b1) begin
                rsp_ch.ready <= 1'b0;
                run_left = $urandom_range(3);
            end else begin
                rsp_ch.ready <= 1'b1;
                run_left = ($urandom_range(5) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(15);
            end
        end
    end

    // response checker, field by field against the oldest expectation
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected response transaction found %0b frame %0d count %0d",
                         $time, rsp_ch.found, rsp_ch.victim_frame, rsp_ch.evictable_count);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                if (rsp_ch.found !== want.found) begin
                    $display("%0t: found expected %0b got %0b",
                             $time, want.found, rsp_ch.found);
                    mismatches++;
                end
                if (rsp_ch.victim_frame !== want.victim_frame) begin
                    $display("%0t: victim_frame expected %0d got %0d",
                             $time, want.victim_frame, rsp_ch.victim_frame);
                    mismatches++;
                end
                if (rsp_ch.evictable_count !== want.evictable_count) begin
                    $display("%0t: evictable_count expected %0d got %0d",
                             $time, want.evictable_count, rsp_ch.evictable_count);
                    mismatches++;
                end
            end
        end
    end

    // main stimulus
    initial begin
        t_request r;
        int       ids [DEF_NUM_FRAMES];
        int       j;
        int       tmp;
        int       n;
        int       holds_done;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.command     = CMD_VICTIM;
        req_ch.frame_index = '0;
        hold_req    = 1'b0;
        mismatches  = 0;
        work_items  = 0;
        cycle_count = 0;
        set_count   = 0;
        holds_done  = 0;
        burst_left  = $urandom_range(1, 12);
        foreach (in_set[i])
            in_set[i] = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < DIRECTED_LEN; i++)
            offer(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        settle_requests();
        work_items = 0;

        // random sequences until enough real work has gone through
        while (work_items < WORK_TARGET) begin
            if (holds_done < 2 && work_items >= holds_done * 700) begin
                hold_req = 1'b1;
                holds_done++;
                run_churn(40);
            end
            case ($urandom_range(9))
                0, 1: begin
                    // unpin every frame in a shuffled order, reaching a full set
                    foreach (ids[i])
                        ids[i] = i;
                    for (int i = DEF_NUM_FRAMES - 1; i > 0; i--) begin
                        j      = $urandom_range(i);
                        tmp    = ids[i];
                        ids[i] = ids[j];
                        ids[j] = tmp;
                    end
                    r.command = CMD_UNPIN;
                    foreach (ids[i]) begin
                        r.frame_index = FRAME_W'(ids[i]);
                        offer(r);
                    end
                end
                2: begin
                    // drain by victims, running past empty
                    n = set_count + $urandom_range(1, 3);
                    r.command = CMD_VICTIM;
                    for (int i = 0; i < n; i++) begin
                        r.frame_index = FRAME_W'($urandom_range(DEF_NUM_FRAMES - 1));
                        offer(r);
                    end
                end
                3: begin
                    // pin present frames from random positions
                    n = $urandom_range(0, set_count) + 2;
                    r.command = CMD_PIN;
                    for (int i = 0; i < n; i++) begin
                        r.frame_index = pick_present();
                        offer(r);
                    end
                end
                4: begin
                    // unbiased noise including the unused command
                    n = $urandom_range(10, 30);
                    for (int i = 0; i < n; i++) begin
                        r.command     = CMD_W'($urandom_range(3));
                        r.frame_index = FRAME_W'($urandom_range(DEF_NUM_FRAMES - 1));
                        offer(r);
                    end
                end
                default: run_churn($urandom_range(20, 80));
            endcase
            if ($urandom_range(7) == 0)
                settle_requests();
        end

        settle_requests();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lfr_pkg.sv
hdl/lfr_if.sv
hdl/lfr_cell.sv
hdl/lfr_scan.sv
hdl/lru_frame_replacer.sv
sim/tb_lru_frame_replacer.sv
